>>> src/mhpq_pkg.sv
// Package: shared types, constants and operation/status codes for the heap queue.
package mhpq_pkg;

  localparam int unsigned CAPACITY_DEF = 256;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NOT_LOWER = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [9:0]         cell_x;
    logic [9:0]         cell_y;
    logic signed [15:0] heading;
    logic [23:0]        path_cost;
    logic [23:0]        priority_req;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               entry_valid;
    logic [9:0]         out_cell_x;
    logic [9:0]         out_cell_y;
    logic signed [15:0] out_heading;
    logic [23:0]        out_path_cost;
    logic [23:0]        out_priority;
    logic [8:0]         entry_count;
  } rsp_t;

  // one stored entry: key plus payload {path_cost, heading, y, x}
  typedef struct packed {
    logic [23:0] key;
    logic [23:0] path_cost;
    logic [15:0] heading;
    logic [9:0]  cell_y;
    logic [9:0]  cell_x;
  } entry_t;

  // controller to datapath commands
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_INS_START,
    CMD_UP_RD,
    CMD_UP_MOVE,
    CMD_WR_MOV,
    CMD_POP_RD_ROOT,
    CMD_POP_RD_LAST,
    CMD_POP_GET_LAST,
    CMD_DN_RD_L,
    CMD_DN_RD_R,
    CMD_DN_MOVE,
    CMD_SRCH_START,
    CMD_SRCH_RD,
    CMD_SRCH_NEXT,
    CMD_UPD_START,
    CMD_RD_ROOT,
    CMD_CAPTURE
  } cmd_e;

  typedef struct packed {
    cmd_e    cmd;
    status_e status;
    logic    use_pop;
  } ctl_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic at_root;
    logic up_swap;
    logic is_leaf;
    logic dn_swap;
    logic srch_end;
    logic match;
    logic cheaper;
  } sts_t;

endpackage

>>> src/mhpq_datapath.sv
// Datapath: heap memory, index registers, compares and result register.
module mhpq_datapath #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mhpq_pkg::req_t  req_i,
  input  mhpq_pkg::ctl_t  ctl_i,
  output mhpq_pkg::sts_t  sts_o,
  output mhpq_pkg::rsp_t  rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = CW + 1;   // holds 2i+2

  mhpq_pkg::entry_t mem_q [CAPACITY];
  mhpq_pkg::entry_t rd_q;
  mhpq_pkg::entry_t mov_q, lft_q, pop_q;
  mhpq_pkg::req_t   req_q;
  mhpq_pkg::rsp_t   rsp_q, rsp_w;
  mhpq_pkg::entry_t new_w, shown_w;
  logic [CW-1:0]    cnt_q, idx_q, par_w;
  logic [XW-1:0]    l_w, r_w, cnt_x;
  logic [23:0]      best_key;
  logic             left_lt, right_lt;

  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_en;
  mhpq_pkg::entry_t wr_data;

  // neighbour indexes of the current node
  assign par_w = (idx_q - 1'b1) >> 1;
  assign l_w   = {idx_q, 1'b1};
  assign r_w   = l_w + 1'b1;
  assign cnt_x = {1'b0, cnt_q};

  assign new_w = '{key: req_q.priority_req, path_cost: req_q.path_cost,
                   heading: req_q.heading, cell_y: req_q.cell_y, cell_x: req_q.cell_x};

  // sift down: smaller of node and left, then right against that
  assign left_lt  = (lft_q.key < mov_q.key);
  assign best_key = left_lt ? lft_q.key : mov_q.key;
  assign right_lt = (r_w < cnt_x) && (rd_q.key < best_key);

  // memory ports
  always_comb begin
    rd_addr = idx_q[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_data = mov_q;
    unique case (ctl_i.cmd)
      mhpq_pkg::CMD_UP_RD:       rd_addr = par_w[AW-1:0];
      mhpq_pkg::CMD_UP_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_q;
      end
      mhpq_pkg::CMD_WR_MOV:      wr_en = 1'b1;
      mhpq_pkg::CMD_RD_ROOT:     rd_addr = '0;
      mhpq_pkg::CMD_POP_RD_ROOT: rd_addr = '0;
      mhpq_pkg::CMD_POP_RD_LAST: rd_addr = cnt_q[AW-1:0];
      mhpq_pkg::CMD_DN_RD_L:     rd_addr = l_w[AW-1:0];
      mhpq_pkg::CMD_DN_RD_R:     rd_addr = r_w[AW-1:0];
      mhpq_pkg::CMD_DN_MOVE: begin
        wr_en   = 1'b1;
        wr_data = right_lt ? rd_q : lft_q;
      end
      mhpq_pkg::CMD_SRCH_RD:     rd_addr = idx_q[AW-1:0];
      default: ;
    endcase
  end

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // response word: popped entry, else root when the heap holds one
  assign shown_w = ctl_i.use_pop ? pop_q : rd_q;

  always_comb begin
    rsp_w             = '0;
    rsp_w.status      = ctl_i.status;
    rsp_w.entry_count = 9'(cnt_q);
    if (ctl_i.use_pop || (cnt_q != '0)) begin
      rsp_w.entry_valid   = 1'b1;
      rsp_w.out_cell_x    = shown_w.cell_x;
      rsp_w.out_cell_y    = shown_w.cell_y;
      rsp_w.out_heading   = shown_w.heading;
      rsp_w.out_path_cost = shown_w.path_cost;
      rsp_w.out_priority  = shown_w.key;
    end
  end

  // working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      req_q <= '0;
      mov_q <= '0;
      lft_q <= '0;
      pop_q <= '0;
      rsp_q <= '0;
    end else begin
      unique case (ctl_i.cmd)
        mhpq_pkg::CMD_LOAD:         req_q <= req_i;
        mhpq_pkg::CMD_INS_START: begin
          idx_q <= cnt_q;
          mov_q <= new_w;
          cnt_q <= cnt_q + 1'b1;
        end
        mhpq_pkg::CMD_UP_MOVE:      idx_q <= par_w;
        mhpq_pkg::CMD_POP_RD_ROOT:  cnt_q <= cnt_q - 1'b1;
        mhpq_pkg::CMD_POP_RD_LAST:  pop_q <= rd_q;
        mhpq_pkg::CMD_POP_GET_LAST: begin
          mov_q <= rd_q;
          idx_q <= '0;
        end
        mhpq_pkg::CMD_DN_RD_R:      lft_q <= rd_q;
        mhpq_pkg::CMD_DN_MOVE:      idx_q <= right_lt ? r_w[CW-1:0] : l_w[CW-1:0];
        mhpq_pkg::CMD_SRCH_START:   idx_q <= '0;
        mhpq_pkg::CMD_SRCH_NEXT:    idx_q <= idx_q + 1'b1;
        mhpq_pkg::CMD_UPD_START:    mov_q <= new_w;
        mhpq_pkg::CMD_CAPTURE:      rsp_q <= rsp_w;
        default: ;
      endcase
    end
  end

  // status to the controller
  always_comb begin
    sts_o.op       = mhpq_pkg::op_e'(req_q.operation);
    sts_o.empty    = (cnt_q == '0);
    sts_o.full     = (cnt_q >= CW'(CAPACITY));
    sts_o.at_root  = (idx_q == '0);
    sts_o.up_swap  = (rd_q.key > mov_q.key);
    sts_o.is_leaf  = (l_w >= cnt_x);
    sts_o.dn_swap  = left_lt || right_lt;
    sts_o.srch_end = (idx_q >= cnt_q);
    sts_o.match    = (rd_q.cell_x == req_q.cell_x) && (rd_q.cell_y == req_q.cell_y);
    sts_o.cheaper  = (req_q.path_cost < rd_q.path_cost);
  end

  assign rsp_o = rsp_q;

endmodule

>>> src/min_heap_priority_queue_top.sv
// Top level and controller of the binary min-heap priority queue.
//
// Requests enter on req_valid_i/req_ready_o carrying req_i (operation, cell,
// heading, path cost, key). Each request gives exactly one response on
// rsp_valid_o/rsp_ready_i: status, count and the popped entry (pop) or the
// current root (all others).
// One request is handled at a time; req_ready_o is high only while idle.
// Each request passes through dispatch, then the insert sift-up, the pop
// sift-down or the update cell search and sift-up, and ends with a write of
// the moved entry, a root read and the capture before rsp_valid_o. A no-op, a
// full insert, an empty pop and an update whose cell is missing or not cheaper
// go straight to the root read.
// Sifts walk at most log2(CAPACITY) levels through one memory port.
// Reset empties the heap at once (count to zero); storage is not cleared.
// While a response waits for rsp_ready_i the request side stays not ready.
//
module min_heap_priority_queue_top #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  mhpq_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output mhpq_pkg::rsp_t rsp_o
);

  mhpq_pkg::ctl_t ctl;
  mhpq_pkg::sts_t sts;

  mhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  mhpq_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .ctl_i (ctl),
    .sts_o (sts),
    .rsp_o (rsp_o)
  );

endmodule

// Controller: sequences insert, pop, update and the response.
module mhpq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  input  mhpq_pkg::sts_t sts_i,
  output mhpq_pkg::ctl_t ctl_o
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_DISPATCH = 15'h0002,
    S_UP_CHK   = 15'h0004,
    S_UP_WAIT  = 15'h0008,
    S_POP_LAST = 15'h0010,
    S_POP_GET  = 15'h0020,
    S_DN_CHK   = 15'h0040,
    S_DN_RD_R  = 15'h0080,
    S_DN_CMP   = 15'h0100,
    S_SRCH_CHK = 15'h0200,
    S_SRCH_CMP = 15'h0400,
    S_PLACE    = 15'h0800,
    S_ROOT_RD  = 15'h1000,
    S_ROOT_CAP = 15'h2000,
    S_RSP      = 15'h4000
  } state_e;

  state_e            state_q, state_d;
  mhpq_pkg::status_e status_q, status_d;
  logic              use_pop_q, use_pop_d;
  mhpq_pkg::cmd_e    cmd;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RSP);
  assign ctl_o       = '{cmd: cmd, status: status_q, use_pop: use_pop_q};

  // next state and command
  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    use_pop_d = use_pop_q;
    cmd       = mhpq_pkg::CMD_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd       = mhpq_pkg::CMD_LOAD;
          status_d  = mhpq_pkg::ST_OK;
          use_pop_d = 1'b0;
          state_d   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.op)
          mhpq_pkg::OP_INSERT: begin
            if (sts_i.full) begin
              status_d = mhpq_pkg::ST_FULL;
              state_d  = S_ROOT_RD;
            end else begin
              cmd     = mhpq_pkg::CMD_INS_START;
              state_d = S_UP_CHK;
            end
          end
          mhpq_pkg::OP_POP: begin
            if (sts_i.empty) begin
              status_d = mhpq_pkg::ST_EMPTY;
              state_d  = S_ROOT_RD;
            end else begin
              cmd       = mhpq_pkg::CMD_POP_RD_ROOT;
              use_pop_d = 1'b1;
              state_d   = S_POP_LAST;
            end
          end
          mhpq_pkg::OP_UPDATE: begin
            cmd     = mhpq_pkg::CMD_SRCH_START;
            state_d = S_SRCH_CHK;
          end
          mhpq_pkg::OP_NONE: state_d = S_ROOT_RD;
        endcase
      end
      // sift up: read parent, move it down while it is larger
      S_UP_CHK: begin
        if (sts_i.at_root) begin
          state_d = S_PLACE;
        end else begin
          cmd     = mhpq_pkg::CMD_UP_RD;
          state_d = S_UP_WAIT;
        end
      end
      S_UP_WAIT: begin
        if (sts_i.up_swap) begin
          cmd     = mhpq_pkg::CMD_UP_MOVE;
          state_d = S_UP_CHK;
        end else begin
          state_d = S_PLACE;
        end
      end
      // pop: keep root, take last entry as the one to sink
      S_POP_LAST: begin
        cmd     = mhpq_pkg::CMD_POP_RD_LAST;
        state_d = S_POP_GET;
      end
      S_POP_GET: begin
        cmd     = mhpq_pkg::CMD_POP_GET_LAST;
        state_d = S_DN_CHK;
      end
      // sift down: read both children, move the smaller up
      S_DN_CHK: begin
        if (sts_i.is_leaf) begin
          state_d = S_PLACE;
        end else begin
          cmd     = mhpq_pkg::CMD_DN_RD_L;
          state_d = S_DN_RD_R;
        end
      end
      S_DN_RD_R: begin
        cmd     = mhpq_pkg::CMD_DN_RD_R;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts_i.dn_swap) begin
          cmd     = mhpq_pkg::CMD_DN_MOVE;
          state_d = S_DN_CHK;
        end else begin
          state_d = S_PLACE;
        end
      end
      // cell search over live entries in storage order
      S_SRCH_CHK: begin
        if (sts_i.srch_end) begin
          status_d = mhpq_pkg::ST_NOT_FOUND;
          state_d  = S_ROOT_RD;
        end else begin
          cmd     = mhpq_pkg::CMD_SRCH_RD;
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (sts_i.match) begin
          if (sts_i.cheaper) begin
            cmd     = mhpq_pkg::CMD_UPD_START;
            state_d = S_UP_CHK;
          end else begin
            status_d = mhpq_pkg::ST_NOT_LOWER;
            state_d  = S_ROOT_RD;
          end
        end else begin
          cmd     = mhpq_pkg::CMD_SRCH_NEXT;
          state_d = S_SRCH_CHK;
        end
      end
      S_PLACE: begin
        cmd     = mhpq_pkg::CMD_WR_MOV;
        state_d = S_ROOT_RD;
      end
      S_ROOT_RD: begin
        cmd     = mhpq_pkg::CMD_RD_ROOT;
        state_d = S_ROOT_CAP;
      end
      S_ROOT_CAP: begin
        cmd     = mhpq_pkg::CMD_CAPTURE;
        state_d = S_RSP;
      end
      S_RSP: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      status_q  <= mhpq_pkg::ST_OK;
      use_pop_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      status_q  <= status_d;
      use_pop_q <= use_pop_d;
    end
  end

endmodule
